[rtl/mmmt_pkg.sv]
package mmmt_pkg;

  localparam int VAL_W  = 32;
  localparam int SUM_W  = 40;
  localparam int MEAN_W = 40;

  localparam int DEF_CAPACITY      = 256;
  localparam int DEF_FRACTION_BITS = 8;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef struct packed {
    logic              mode;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                     is_empty;
    logic signed [VAL_W-1:0]  minimum;
    logic signed [VAL_W-1:0]  maximum;
    logic signed [MEAN_W-1:0] mean_fixed;
    logic                     was_found;
    logic                     full_drop;
  } res_t;

endpackage

[rtl/multiset_min_max_mean_tracker.sv]
// Channel   Signals            Direction  Transfer
// command   start, busy, cmd   in         rising edge with start high and busy low
// result    done, result       out        every cycle with done high
//
// Insert: the entry is written to the store on acceptance unless it is full, then the mean divider runs.
// Remove: one pass over the store RAM read port finds the match and the new minimum
// and maximum, then the divider runs unless the store is left empty.
// Reset (rst, synchronous) empties the store at once; no clearing pass.
// done is high for one cycle per command; the receiver cannot stall.
module multiset_min_max_mean_tracker
  import mmmt_pkg::*;
#(
  parameter int CAPACITY      = DEF_CAPACITY,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t result
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DIV_W  = SUM_W + FRACTION_BITS;
  localparam logic [DIV_W-1:0] POS_LIM = DIV_W'(MEAN_MAX);
  localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(MEAN_MAX) + DIV_W'(1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MEAN = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  logic signed [VAL_W-1:0] cur_min, cur_max, scan_min, scan_max, last_val, op_val;
  logic                    found, dropped, have_any, chk_valid;
  logic [CNT_W-1:0]        rd_ptr;
  logic [ADDR_W-1:0]       chk_idx, hit_idx;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;
  logic signed [VAL_W-1:0] ram_rdata;

  logic                    accept, rd_en, scan_end;
  logic [SUM_W-1:0]        mag;
  logic [DIV_W-1:0]        dividend, quo;
  logic                    div_start, div_done;
  logic [MEAN_W-1:0]       mean_sat;

  assign busy     = state != S_IDLE;
  assign accept   = start && !busy;
  assign rd_en    = rd_ptr < count;
  assign scan_end = !rd_en && !chk_valid;

  assign mag       = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
  assign dividend  = DIV_W'(mag) << FRACTION_BITS;
  assign div_start = (state == S_MEAN) && (count != '0);

  always_comb begin
    if (sum[SUM_W-1]) begin
      mean_sat = (quo > NEG_LIM) ? MEAN_MIN : (~quo[MEAN_W-1:0] + MEAN_W'(1));
    end else begin
      mean_sat = (quo > POS_LIM) ? MEAN_MAX : quo[MEAN_W-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[ADDR_W-1:0];
    ram_wdata = cmd.value;
    if (accept && cmd.mode == MODE_INSERT && count < CNT_W'(CAPACITY)) begin
      ram_we = 1'b1;
    end else if (state == S_SCAN && scan_end && found
                 && CNT_W'(hit_idx) != count - CNT_W'(1)) begin
      ram_we    = 1'b1;
      ram_waddr = hit_idx;
      ram_wdata = last_val;
    end
  end

  mmmt_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_ptr[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  mmmt_div #(
    .DW(DIV_W),
    .VW(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (count),
    .done    (div_done),
    .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sum       <= '0;
      cur_min   <= '0;
      cur_max   <= '0;
      done      <= 1'b0;
      chk_valid <= 1'b0;
      rd_ptr    <= '0;
      found     <= 1'b0;
      dropped   <= 1'b0;
      have_any  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_val    <= cmd.value;
            found     <= 1'b0;
            dropped   <= 1'b0;
            have_any  <= 1'b0;
            rd_ptr    <= '0;
            chk_valid <= 1'b0;
            if (cmd.mode == MODE_INSERT) begin
              state <= S_MEAN;
              if (count >= CNT_W'(CAPACITY)) begin
                dropped <= 1'b1;
              end else begin
                found <= 1'b1;
                count <= count + CNT_W'(1);
                if (count == '0) begin
                  cur_min <= cmd.value;
                  cur_max <= cmd.value;
                  sum     <= SUM_W'(cmd.value);
                end else begin
                  if (cmd.value < cur_min) cur_min <= cmd.value;
                  if (cmd.value > cur_max) cur_max <= cmd.value;
                  sum <= sum + SUM_W'(cmd.value);
                end
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_valid <= rd_en;
          chk_idx   <= rd_ptr[ADDR_W-1:0];
          if (rd_en) begin
            rd_ptr <= rd_ptr + CNT_W'(1);
          end
          if (chk_valid) begin
            if (CNT_W'(chk_idx) == count - CNT_W'(1)) begin
              last_val <= ram_rdata;
            end
            if (!found && ram_rdata == op_val) begin
              found   <= 1'b1;
              hit_idx <= chk_idx;
            end else if (!have_any) begin
              have_any <= 1'b1;
              scan_min <= ram_rdata;
              scan_max <= ram_rdata;
            end else begin
              if (ram_rdata < scan_min) scan_min <= ram_rdata;
              if (ram_rdata > scan_max) scan_max <= ram_rdata;
            end
          end
          if (scan_end) begin
            state <= S_MEAN;
            if (found) begin
              count <= count - CNT_W'(1);
              if (count == CNT_W'(1)) begin
                sum     <= '0;
                cur_min <= '0;
                cur_max <= '0;
              end else begin
                cur_min <= scan_min;
                cur_max <= scan_max;
                sum     <= sum - SUM_W'(op_val);
              end
            end
          end
        end
        S_MEAN: begin
          if (count == '0) begin
            result.is_empty   <= 1'b1;
            result.minimum    <= '0;
            result.maximum    <= '0;
            result.mean_fixed <= '0;
            result.was_found  <= found;
            result.full_drop  <= dropped;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            result.is_empty   <= 1'b0;
            result.minimum    <= cur_min;
            result.maximum    <= cur_max;
            result.mean_fixed <= mean_sat;
            result.was_found  <= found;
            result.full_drop  <= dropped;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after transfer");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |->
      (result.minimum == '0 && result.maximum == '0 && result.mean_fixed == '0))
    else $error("empty result carries statistics");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (count == '0)))
    else $error("empty flag disagrees with entry count");

  a_drop_found: assert property (@(posedge clk) disable iff (rst)
    (done && result.full_drop) |-> (!result.was_found && count == CNT_W'(CAPACITY)))
    else $error("drop reported with store not full");

endmodule

[rtl/mmmt_ram.sv]
module mmmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mmmt_div.sv]
module mmmt_div #(
  parameter int DW = 48,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          run;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  assign shifted  = {rem, quo[DW-1]};
  assign ge       = shifted >= {1'b0, dvs};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= CW'(DW);
        run <= 1'b1;
      end else if (run) begin
        if (ge) begin
          rem <= diff[VW-1:0];
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= shifted[VW-1:0];
          quo <= {quo[DW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
